// ===== sv/q6k_pkg.sv =====
// Package with shared types, codes and helpers for the Q6_K block dequantizer.
`timescale 1ns / 1ps
package q6k_pkg;

   typedef enum logic [2:0] {
      FUNC_LOW   = 3'd0,
      FUNC_HIGH  = 3'd1,
      FUNC_SCALE = 3'd2,
      FUNC_D     = 3'd3,
      FUNC_EMIT  = 3'd4
   } func_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [6:0]  index;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] value_bits;
      logic [7:0]  element;
      logic        last_in_run;
   } rsp_type;

   // Command queued between the front end and the emit engine.
   typedef struct packed {
      logic [1:0] quarter;
   } cmd_type;

   localparam int QDEPTH = 2;

   // fp16 to binary32 widening, exact.
   function automatic logic [31:0] half_to_single(input logic [15:0] hv);
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [31:0] r;
      logic [7:0]  e32;
      logic [10:0] m;
      ex  = hv[14:10];
      man = hv[9:0];
      r   = {hv[15], 31'd0};
      e32 = 8'd113;
      m   = {1'b0, man};
      if (ex == 5'd0) begin
         if (man != 10'd0) begin
            for (int i = 0; i < 10; i++) begin
               if (!m[10]) begin
                  m   = m << 1;
                  e32 = e32 - 8'd1;
               end
            end
            r = {hv[15], e32, m[9:0], 13'd0};
         end
      end else if (ex == 5'd31) begin
         r = {hv[15], 8'hFF, man, 13'd0};
      end else begin
         r = {hv[15], 8'(ex) + 8'd112, man, 13'd0};
      end
      return r;
   endfunction

endpackage

// ===== sv/q6k_stream_if.sv =====
// Valid/ready channel interface carrying a generic payload.
`timescale 1ns / 1ps
interface q6k_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/q6k_block_dequantizer.sv =====
// Top level of the Q6_K block dequantizer.
//
// req carries one item per transfer: a byte load into the low, high-bit or
// scale store, a block scale load, or an emit of one quarter of the block.
// Loads give no result; the front end keeps taking them while the back
// end works. An emit is queued (two deep) and the back end then streams
// 64 results on rsp, one per cycle while rsp is ready, with element
// position and a last flag on the 64th. Unless stalled, the back end reads
// the byte stores one element per cycle; it takes the next command from
// the queue only once it has issued the last element of the current one.
// When rsp stalls the back-end pipeline holds; the queue fills and then req
// ready drops. Reset clears the queue and pipeline; stores hold no reset
// value and must be loaded before an emit reads them. Loads that overwrite
// a store while an emit of it is queued change its output, so the host
// waits for the last result before reloading.
`timescale 1ns / 1ps
module q6k_block_dequantizer import q6k_pkg::*; (
   input logic clock,
   input logic reset,
   q6k_stream_if.sink   req,
   q6k_stream_if.source rsp
);
   logic low_we, high_we, sc_we, cmd_valid, cmd_take;
   logic [6:0] wr_addr, low_addr;
   logic [7:0] wr_data, low_data, high_data, sc_data;
   logic [5:0] high_addr;
   logic [3:0] sc_addr;
   logic [15:0] d_bits;
   cmd_type cmd;

   q6k_front u_front (
      .clock, .reset, .req, .low_we, .high_we, .sc_we, .wr_addr, .wr_data,
      .d_bits, .cmd_valid, .cmd, .cmd_take
   );

   q6k_ram #(.WIDTH(8), .DEPTH(128)) u_low (
      .clock, .wr_en(low_we), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(low_addr), .rd_data(low_data)
   );
   q6k_ram #(.WIDTH(8), .DEPTH(64)) u_high (
      .clock, .wr_en(high_we), .wr_addr(wr_addr[5:0]), .wr_data(wr_data),
      .rd_addr(high_addr), .rd_data(high_data)
   );
   q6k_ram #(.WIDTH(8), .DEPTH(16)) u_sc (
      .clock, .wr_en(sc_we), .wr_addr(wr_addr[3:0]), .wr_data(wr_data),
      .rd_addr(sc_addr), .rd_data(sc_data)
   );

   q6k_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_take, .d_bits, .low_addr,
      .high_addr, .sc_addr, .low_data, .high_data, .sc_data, .rsp
   );

   a_take_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("command taken from empty queue");
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.last_in_run |-> rsp.payload.element[5:0] == 6'd63)
      else $error("last flag off the 64th element");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result changed while stalled");
endmodule

// ===== sv/q6k_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module q6k_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== sv/q6k_front.sv =====
// Front end: accepts items, writes the stores and queues emit commands.
`timescale 1ns / 1ps
module q6k_front import q6k_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   q6k_stream_if.sink req,
   output logic       low_we,
   output logic       high_we,
   output logic       sc_we,
   output logic [6:0] wr_addr,
   output logic [7:0] wr_data,
   output logic [15:0] d_bits,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_take
);
   cmd_type   q_ff [QDEPTH];
   logic      wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [15:0] d_ff;
   logic      fire, push;

   assign req.ready = (cnt_ff != 2'(QDEPTH));
   assign fire      = req.valid && req.ready;
   assign push      = fire && (func_type'(req.payload.func) == FUNC_EMIT)
                      && (req.payload.index[6:2] == 5'd0);
   assign low_we    = fire && (func_type'(req.payload.func) == FUNC_LOW);
   assign high_we   = fire && (func_type'(req.payload.func) == FUNC_HIGH)
                      && !req.payload.index[6];
   assign sc_we     = fire && (func_type'(req.payload.func) == FUNC_SCALE)
                      && (req.payload.index[6:4] == 3'd0);
   assign wr_addr   = req.payload.index;
   assign wr_data   = req.payload.value[7:0];
   assign d_bits    = d_ff;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   assign wp_in  = push ? ~wp_ff : wp_ff;
   assign rp_in  = cmd_take ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + 2'(push) - 2'(cmd_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff].quarter <= req.payload.index[1:0];
      if (fire && func_type'(req.payload.func) == FUNC_D) d_ff <= req.payload.value;
   end
endmodule

// ===== sv/q6k_back.sv =====
// Back end: walks 64 elements per command and forms each binary32 value.
`timescale 1ns / 1ps
module q6k_back import q6k_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   input  logic [15:0] d_bits,
   output logic [6:0]  low_addr,
   output logic [5:0]  high_addr,
   output logic [3:0]  sc_addr,
   input  logic [7:0]  low_data,
   input  logic [7:0]  high_data,
   input  logic [7:0]  sc_data,
   q6k_stream_if.source rsp
);
   // Stage 0 issues reads; stage 1 holds data; stage 2 multiplies; output register.
   logic       busy_ff, busy_in;
   logic [7:0] e_ff, e_in;
   logic       v1_ff, v2_ff, vo_ff;
   logic [7:0] e1_ff, e2_ff;
   logic [7:0] ea;
   logic       adv, issue;
   logic [1:0] g1;
   logic [3:0] nib;
   logic [1:0] hb;
   logic signed [6:0] q;
   logic signed [7:0] sc;
   logic signed [14:0] p_in, p2_ff;
   logic       ps_in, ps2_ff;
   logic [31:0] db, db2_ff;
   rsp_type    out_ff, out_in;
   logic [14:0] mag;
   logic [4:0] lz;
   logic [31:0] res;

   // The pipeline advances whenever the output slot is free or being taken.
   assign adv   = !vo_ff || rsp.ready;
   assign issue = busy_ff && adv;
   assign cmd_take = !busy_ff && cmd_valid;

   // While the pipeline holds, the stores are read again at the stage 1 element
   // so that the registered read data stays with it.
   assign ea        = adv ? e_ff : e1_ff;
   assign low_addr  = {ea[7], ea[5], ea[4:0]};
   assign high_addr = {ea[7], ea[4:0]};
   assign sc_addr   = {ea[7], ea[6:5], ea[4]};

   always_comb begin
      busy_in = busy_ff;
      e_in    = e_ff;
      if (cmd_take) begin
         busy_in = 1'b1;
         e_in    = {cmd.quarter, 6'd0};
      end else if (issue) begin
         e_in = e_ff + 8'd1;
         if (e_ff[5:0] == 6'd63) busy_in = 1'b0;
      end
   end

   assign g1  = e1_ff[6:5];
   assign nib = g1[1] ? low_data[7:4] : low_data[3:0];
   assign hb  = 2'(high_data >> {g1, 1'b0});
   assign q   = $signed({1'b0, hb, nib}) - 7'sd32;
   assign sc  = $signed(sc_data);
   assign p_in = 15'(sc) * 15'(q);
   assign ps_in = sc[7] ^ q[6];
   assign db  = half_to_single(d_bits);

   // Convert integer product to float and scale by d (product exact in 24 bits).
   always_comb begin
      logic [25:0] prod;
      logic [8:0]  ex;
      logic        s;
      logic [15:0] tmp;
      mag = p2_ff[14] ? 15'(-p2_ff) : 15'(p2_ff);
      s   = db2_ff[31] ^ ps2_ff;
      lz  = 5'd0;
      for (int i = 14; i >= 0; i--) if (mag[i] && lz == 5'd0) lz = 5'(15 - i);
      res  = {s, 31'd0};
      prod = 26'd0;
      ex   = 9'd0;
      tmp  = 16'd0;
      if (db2_ff[30:23] == 8'hFF) begin
         if (db2_ff[22:0] != 23'd0) res = db2_ff | 32'h0040_0000;
         else if (mag == 15'd0) res = 32'h7FC0_0000;
         else res = {s, 8'hFF, 23'd0};
      end else if (mag != 15'd0 && db2_ff[30:0] != 31'd0) begin
         // d is normal here (fp16 values are normal in binary32).
         tmp  = 16'(mag) << (lz - 5'd1);
         // product of 11-bit d mantissa and normalized 15-bit magnitude
         prod = 26'({1'b1, db2_ff[22:13]}) * 26'(tmp[14:0]);
         ex   = 9'(db2_ff[30:23]) + 9'd15 - 9'(lz);
         if (prod[25]) res = {s, ex[7:0] + 8'd1, prod[24:2]};
         else          res = {s, ex[7:0], prod[23:1]};
      end
   end

   always_comb begin
      out_in = out_ff;
      if (v2_ff) begin
         out_in.value_bits  = res;
         out_in.element     = e2_ff;
         out_in.last_in_run = (e2_ff[5:0] == 6'd63);
      end
   end

   assign rsp.valid   = vo_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         e_ff    <= 8'd0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         vo_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         e_ff    <= e_in;
         if (adv) begin
            v1_ff <= issue;
            v2_ff <= v1_ff;
            vo_ff <= v2_ff;
         end
      end
      if (adv) begin
         e1_ff  <= e_ff;
         e2_ff  <= e1_ff;
         p2_ff  <= p_in;
         ps2_ff <= ps_in;
         db2_ff <= db;
         out_ff <= out_in;
      end
   end
endmodule

// ===== test/q6k_scoreboard.sv =====
// Scoreboard class that predicts and checks the dequantized element stream.
`timescale 1ns / 1ps
package q6k_scoreboard_pkg;
   import q6k_pkg::*;

   class dequant_scoreboard;
      logic [7:0]  low_store[128];
      logic [7:0]  high_store[64];
      logic [7:0]  scale_store[16];
      logic [15:0] d_half;
      rsp_type     expected_q[$];
      int          errors;

      function new();
         errors = 0;
         d_half = '0;
         foreach (low_store[i]) low_store[i] = '0;
         foreach (high_store[i]) high_store[i] = '0;
         foreach (scale_store[i]) scale_store[i] = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Exact widening of an fp16 bit pattern to binary32.
      function logic [31:0] widen_half(logic [15:0] hv);
         logic [4:0]  ex;
         logic [10:0] man;
         logic [7:0]  e32;
         ex  = hv[14:10];
         man = {1'b0, hv[9:0]};
         if (ex == 5'd0) begin
            if (man == 11'd0) return {hv[15], 31'd0};
            e32 = 8'd113;
            while (!man[10]) begin
               man = man << 1;
               e32 = e32 - 8'd1;
            end
            return {hv[15], e32, man[9:0], 13'd0};
         end
         if (ex == 5'd31) return {hv[15], 8'hFF, hv[9:0], 13'd0};
         return {hv[15], 8'(ex) + 8'd112, hv[9:0], 13'd0};
      endfunction

      // Computes d * sc * (q - 32) by exact integer arithmetic.
      function logic [31:0] element_value(int e);
         int          h, g, l, q, sc, n, p;
         logic [7:0]  lb;
         logic [3:0]  nib;
         logic [1:0]  hb;
         logic [5:0]  q6;
         logic [31:0] db;
         logic        sgn;
         logic [63:0] mag, mant;
         logic [8:0]  ex;
         h   = e >> 7;
         g   = (e & 127) >> 5;
         l   = e & 31;
         lb  = low_store[64 * h + l + 32 * (g & 1)];
         nib = (g < 2) ? lb[3:0] : lb[7:4];
         hb  = 2'((high_store[32 * h + l] >> (2 * g)) & 8'd3);
         q6  = {hb, nib};
         q   = int'(q6) - 32;
         sc  = int'($signed(scale_store[8 * h + l / 16 + 2 * g]));
         db  = widen_half(d_half);
         n   = sc * q;
         sgn = db[31] ^ (sc < 0) ^ (q < 0);
         if (db[30:23] == 8'hFF) begin
            if (db[22:0] != 23'd0) return db | 32'h0040_0000;
            if (n == 0) return 32'h7FC0_0000;
            return {sgn, 8'hFF, 23'd0};
         end
         if (db[30:0] == 31'd0 || n == 0) return {sgn, 31'd0};
         mag = {40'd0, 1'b1, db[22:0]} * 64'((n < 0) ? -n : n);
         p = 0;
         for (int i = 0; i < 64; i++) if (mag[i]) p = i;
         ex   = 9'(db[30:23]) + 9'(p) - 9'd23;
         mant = (p > 23) ? (mag >> (p - 23)) : (mag << (23 - p));
         return {sgn, ex[7:0], mant[22:0]};
      endfunction

      function void note_request(req_type r);
         rsp_type x;
         case (r.func)
            FUNC_LOW:   low_store[r.index] = r.value[7:0];
            FUNC_HIGH:  if (r.index < 7'd64) high_store[r.index[5:0]] = r.value[7:0];
            FUNC_SCALE: if (r.index < 7'd16) scale_store[r.index[3:0]] = r.value[7:0];
            FUNC_D:     d_half = r.value;
            FUNC_EMIT: begin
               if (r.index < 7'd4) begin
                  for (int k = 0; k < 64; k++) begin
                     x.value_bits  = element_value(int'(r.index) * 64 + k);
                     x.element     = 8'(int'(r.index) * 64 + k);
                     x.last_in_run = (k == 63);
                     expected_q.push_back(x);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_response(rsp_type a);
         rsp_type x;
         if (expected_q.size() == 0) begin
            $error("unexpected result: element %0d value_bits %h", a.element, a.value_bits);
            errors++;
            return;
         end
         x = expected_q.pop_front();
         if (a.value_bits !== x.value_bits) begin
            $error("value_bits mismatch: expected %h actual %h", x.value_bits, a.value_bits);
            errors++;
         end
         if (a.element !== x.element) begin
            $error("element mismatch: expected %0d actual %0d", x.element, a.element);
            errors++;
         end
         if (a.last_in_run !== x.last_in_run) begin
            $error("last_in_run mismatch: expected %b actual %b",
                   x.last_in_run, a.last_in_run);
            errors++;
         end
      endfunction
   endclass
endpackage

// ===== test/tb_q6k_block_dequantizer.sv =====
// Testbench top for the Q6_K block dequantizer.
`timescale 1ns / 1ps
module tb_q6k_block_dequantizer;
   import q6k_pkg::*;
   import q6k_scoreboard_pkg::*;

   localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
   localparam int ITEM_TARGET = 380;

   logic clock = 1'b0;
   logic reset = 1'b1;

   q6k_stream_if #(.payload_type(req_type)) req_chan (clock);
   q6k_stream_if #(.payload_type(rsp_type)) rsp_chan (clock);

   q6k_block_dequantizer u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_chan.sink),
      .rsp   (rsp_chan.source)
   );

   dequant_scoreboard sb = new();
   int sent = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int cycle_count = 0;
   logic [15:0] d_specials[13] = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h03FF,
                                   16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00, 16'h7E00,
                                   16'h7C01, 16'hFFFF, 16'h3C00};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
   end

   // The receiver switches between always ready, random stalls and a fixed pattern.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) stall_mode <= $urandom_range(2, 0);
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(9, 0) < 7);
         default: rsp_chan.ready <= ((cycle_count % 8) > 2);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_request(req_chan.payload);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_response(rsp_chan.payload);
      end
   end

   task automatic send(logic [2:0] f, logic [6:0] idx, logic [15:0] val);
      req_type item;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      item.func  = f;
      item.index = idx;
      item.value = val;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   // Waits until every expected result has arrived, then lets the back end settle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every store so no emit ever reads an unwritten entry.
      for (int i = 0; i < 128; i++)
         send(FUNC_LOW, 7'(i), (i == 0) ? 16'hFF00 : (i == 1) ? 16'h00FF : 16'($urandom));
      for (int i = 0; i < 64; i++)
         send(FUNC_HIGH, 7'(i), (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom));
      send(FUNC_SCALE, 7'd0, 16'h0080);
      send(FUNC_SCALE, 7'd1, 16'h007F);
      send(FUNC_SCALE, 7'd2, 16'hFF00);
      send(FUNC_SCALE, 7'd3, 16'h00FF);
      for (int i = 4; i < 16; i++) send(FUNC_SCALE, 7'(i), 16'($urandom));
      send(FUNC_D, 7'd127, 16'h3C00);
      // Writes and emits that must leave no trace.
      send(FUNC_HIGH, 7'd64, 16'hFFFF);
      send(FUNC_HIGH, 7'd127, 16'h00AA);
      send(FUNC_SCALE, 7'd16, 16'h0055);
      send(FUNC_SCALE, 7'd127, 16'h0080);
      send(FUNC_EMIT, 7'd4, 16'h0000);
      send(FUNC_EMIT, 7'd127, 16'hFFFF);
      for (logic [3:0] f = FUNC_UNUSED_LO; f <= FUNC_UNUSED_HI; f++)
         send(f[2:0], 7'($urandom), 16'($urandom));
      for (int qtr = 0; qtr < 4; qtr++) send(FUNC_EMIT, 7'(qtr), 16'($urandom));
      drain();

      for (int r = 0; sent < ITEM_TARGET; r++) begin
         n = $urandom_range(10, 3);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(9, 0))
               0, 1, 2: send(FUNC_LOW, 7'($urandom), 16'($urandom));
               3, 4:    send(FUNC_HIGH, 7'($urandom_range(70, 0)), 16'($urandom));
               5, 6:    send(FUNC_SCALE, 7'($urandom_range(20, 0)), 16'($urandom));
               7:       send(FUNC_UNUSED_LO + 3'($urandom_range(2, 0)),
                             7'($urandom), 16'($urandom));
               default: send(FUNC_D, 7'($urandom),
                             (r < 13) ? d_specials[r]
                             : ($urandom_range(2, 0) == 0) ? d_specials[$urandom_range(12, 0)]
                             : 16'($urandom));
            endcase
         end
         if (r < 13) send(FUNC_D, 7'($urandom), d_specials[r]);
         n = $urandom_range(3, 1);
         for (int i = 0; i < n; i++)
            send(FUNC_EMIT, ($urandom_range(7, 0) == 0) ? 7'($urandom_range(127, 4))
                                                       : 7'($urandom_range(3, 0)),
                 16'($urandom));
         drain();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_q6k_block_dequantizer: PASS");
      end else begin
         $display("tb_q6k_block_dequantizer: FAIL");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb_q6k_block_dequantizer: FAIL");
      $finish;
   end
endmodule
